/* rtl/jss_pkg.sv */
`default_nettype none

package jss_pkg;

  // Fixed geometry of the block
  localparam int NUM_JOINTS = 9;
  localparam int FRAC_BITS  = 12;
  localparam int JOINT_W    = 4;
  localparam int ANG_W      = 18;
  localparam int CMD_W      = 24;
  localparam int GAIN_W     = 16;
  localparam int ALPHA_W    = 13;
  localparam int STEP_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;
  localparam int JIDX_W     = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

  // Fixed-point constants: PI_Q30 is scaled by 2^30, PI_Q and ONE_Q by 2^FRAC_BITS
  localparam longint PI_Q30  = 64'sd3373259426;
  localparam longint PI_Q    = (PI_Q30 + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
  localparam longint ONE_Q   = 64'sd1 <<< FRAC_BITS;
  localparam longint CMD_MAX = (64'sd1 <<< (CMD_W - 1)) - 64'sd1;
  localparam longint CMD_MIN = -(64'sd1 <<< (CMD_W - 1));

  localparam longint RST_GAIN  = ONE_Q / 2;
  localparam longint RST_ALPHA = ONE_Q / 2;
  localparam longint RST_STEP  = (ONE_Q * 5 + 50) / 100;
  localparam longint RST_CLAMP = (ONE_Q * 157 + 50) / 100;

  // Datapath widths
  localparam int C_W   = 20;
  localparam int B_W   = (FRAC_BITS + 2 > GAIN_W + 1) ? FRAC_BITS + 2 : GAIN_W + 1;
  localparam int P_W   = CMD_W + B_W;
  localparam int ACC_W = P_W + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN         = 3'd0,
    CFG_SMOOTH_ALPHA = 3'd1,
    CFG_STEP_MAX     = 3'd2,
    CFG_CLAMP_ENABLE = 3'd3,
    CFG_CLAMP_MIN    = 3'd4,
    CFG_CLAMP_MAX    = 3'd5,
    CFG_INVERT       = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_SAMPLE   = 2'd0,
    ST_CAPTURED = 2'd1,
    ST_REJECTED = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain;
    logic [ALPHA_W-1:0]       smooth_alpha;
    logic [STEP_W-1:0]        step_max;
    logic                     clamp_enable;
    logic signed [ANG_W-1:0]  clamp_min;
    logic signed [ANG_W-1:0]  clamp_max;
    logic                     invert;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic wrap_step;
    logic gain;
    logic mapq;
    logic mul_prev;
    logic mul_new;
    logic slew;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic req_func;
    logic req_in_range;
    logic req_angle_valid;
    logic wrap_done;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

/* rtl/jss_cfg.sv */
`default_nettype none

module jss_cfg import jss_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                       cfg_o
);

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // Decode the index; codes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain         <= GAIN_W'(RST_GAIN);
      cfg_q.smooth_alpha <= ALPHA_W'(RST_ALPHA);
      cfg_q.step_max     <= STEP_W'(RST_STEP);
      cfg_q.clamp_enable <= 1'b1;
      cfg_q.clamp_min    <= ANG_W'(-RST_CLAMP);
      cfg_q.clamp_max    <= ANG_W'(RST_CLAMP);
      cfg_q.invert       <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_GAIN:         cfg_q.gain         <= cfg_data_i[GAIN_W-1:0];
        CFG_SMOOTH_ALPHA: cfg_q.smooth_alpha <= cfg_data_i[ALPHA_W-1:0];
        CFG_STEP_MAX:     cfg_q.step_max     <= cfg_data_i[STEP_W-1:0];
        CFG_CLAMP_ENABLE: cfg_q.clamp_enable <= cfg_data_i[0];
        CFG_CLAMP_MIN:    cfg_q.clamp_min    <= cfg_data_i[ANG_W-1:0];
        CFG_CLAMP_MAX:    cfg_q.clamp_max    <= cfg_data_i[ANG_W-1:0];
        CFG_INVERT:       cfg_q.invert       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/jss_ctrl.sv */
`default_nettype none

module jss_ctrl import jss_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t       cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_WRAP = 8'b0000_0010,
    S_GAIN = 8'b0000_0100,
    S_MAPQ = 8'b0000_1000,
    S_MULP = 8'b0001_0000,
    S_MULQ = 8'b0010_0000,
    S_SLEW = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (stat_i.req_func || !stat_i.req_in_range) begin
            state_d = S_DONE;
          end else if (!stat_i.req_angle_valid) begin
            state_d = S_MAPQ;
          end else begin
            state_d = S_WRAP;
          end
        end
      end
      S_WRAP: begin
        if (stat_i.wrap_done) begin
          state_d = S_GAIN;
        end
      end
      S_GAIN: state_d = S_MAPQ;
      S_MAPQ: state_d = S_MULP;
      S_MULP: state_d = S_MULQ;
      S_MULQ: state_d = S_SLEW;
      S_SLEW: state_d = S_DONE;
      S_DONE: begin
        if (stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o.accept    = (state_q == S_IDLE) && in_valid_i;
    cmd_o.wrap_step = (state_q == S_WRAP);
    cmd_o.gain      = (state_q == S_GAIN);
    cmd_o.mapq      = (state_q == S_MAPQ);
    cmd_o.mul_prev  = (state_q == S_MULP);
    cmd_o.mul_new   = (state_q == S_MULQ);
    cmd_o.slew      = (state_q == S_SLEW);
    cmd_o.commit    = (state_q == S_DONE) && stat_i.out_free;
  end

endmodule

`default_nettype wire

/* rtl/jss_dp.sv */
`default_nettype none

module jss_dp import jss_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire cfg_t                    cfg_i,
  input  wire dp_cmd_t                 cmd_i,
  output dp_stat_t                     stat_o,
  input  wire logic                    func_i,
  input  wire logic [JOINT_W-1:0]      joint_i,
  input  wire logic                    angle_valid_i,
  input  wire logic signed [ANG_W-1:0] angle_rad_i,
  input  wire logic                    out_stall_i,
  output logic                         out_valid_o,
  output logic [JOINT_W-1:0]           joint_out_o,
  output logic signed [CMD_W-1:0]      command_o,
  output logic [1:0]                   status_o
);

  localparam logic signed [C_W-1:0]   PI_C     = C_W'(PI_Q);
  localparam logic signed [C_W-1:0]   TWO_PI_C = C_W'(2 * PI_Q);
  localparam logic signed [B_W-1:0]   ONE_B    = B_W'(ONE_Q);
  localparam logic signed [ACC_W-1:0] HALF_A   = ACC_W'(ONE_Q >>> 1);
  localparam logic signed [ACC_W-1:0] MAX_A    = ACC_W'(CMD_MAX);
  localparam logic signed [ACC_W-1:0] MIN_A    = ACC_W'(CMD_MIN);

  function automatic logic signed [CMD_W-1:0] sat_cmd(input logic signed [ACC_W-1:0] v);
    logic signed [CMD_W-1:0] r;
    if (v > MAX_A) begin
      r = CMD_W'(CMD_MAX);
    end else if (v < MIN_A) begin
      r = CMD_W'(CMD_MIN);
    end else begin
      r = v[CMD_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [ACC_W-1:0] clamp_val(
    input logic signed [ACC_W-1:0] v,
    input logic                    en,
    input logic signed [ACC_W-1:0] lo,
    input logic signed [ACC_W-1:0] hi
  );
    logic signed [ACC_W-1:0] r;
    r = v;
    if (en) begin
      if (r > hi) r = hi;
      if (r < lo) r = lo;
    end
    return r;
  endfunction

  // Item registers
  logic                    func_q, valid_q, in_range_q, wrap_hi_q, wrap_lo_q;
  logic [JOINT_W-1:0]      joint_q;
  logic [JIDX_W-1:0]       idx;
  logic signed [C_W-1:0]   c_q, c_d, ang_ext, c_neg;
  logic signed [ACC_W-1:0] acc_q, acc_d, s_q, s_d;
  logic signed [CMD_W-1:0] q_q, q_d;

  // Per-joint state
  logic signed [CMD_W-1:0] last_q   [NUM_JOINTS];
  logic signed [CMD_W-1:0] latest_q [NUM_JOINTS];
  logic signed [CMD_W-1:0] offset_q [NUM_JOINTS];
  logic                    have_q;
  logic signed [CMD_W-1:0] prev_rd, off_rd;

  // Output register
  logic                    out_valid_q;
  logic [JOINT_W-1:0]      out_joint_q;
  logic signed [CMD_W-1:0] out_cmd_q;
  status_e                 out_status_q;
  logic                    out_free;

  // Configuration views as signed words
  logic signed [ACC_W-1:0] cmin_a, cmax_a, step_a;
  logic signed [B_W-1:0]   gain_b, alpha_eff, one_minus;
  logic [B_W-1:0]          alpha_u;

  // Shared multiplier
  logic signed [CMD_W-1:0] mul_a;
  logic signed [B_W-1:0]   mul_b;
  logic signed [P_W-1:0]   prod;

  logic signed [ACC_W-1:0] rnd, mapped, prev_a, delta, fin_a;
  logic signed [CMD_W-1:0] fin;
  logic                    last_all_zero;

  assign idx      = joint_q[JIDX_W-1:0];
  assign prev_rd  = last_q[idx];
  assign off_rd   = offset_q[idx];
  assign ang_ext  = C_W'(angle_rad_i);
  assign out_free = !out_valid_q || !out_stall_i;

  assign stat_o.req_func        = func_i;
  assign stat_o.req_in_range    = ({1'b0, joint_i} < (JOINT_W + 1)'(NUM_JOINTS));
  assign stat_o.req_angle_valid = angle_valid_i;
  assign stat_o.wrap_done       = !((wrap_hi_q && (c_q >= PI_C)) ||
                                    (wrap_lo_q && (c_q < -PI_C)));
  assign stat_o.out_free        = out_free;

  assign cmin_a    = ACC_W'(cfg_i.clamp_min);
  assign cmax_a    = ACC_W'(cfg_i.clamp_max);
  assign step_a    = signed'(ACC_W'(cfg_i.step_max));
  assign gain_b    = B_W'(cfg_i.gain);
  assign alpha_u   = B_W'(cfg_i.smooth_alpha);
  assign alpha_eff = (alpha_u > B_W'(ONE_Q)) ? ONE_B : signed'(alpha_u);
  assign one_minus = ONE_B - alpha_eff;

  assign c_neg = cfg_i.invert ? -c_q : c_q;

  // Pick multiplier operands by step
  always_comb begin
    mul_a = CMD_W'(c_neg);
    mul_b = gain_b;
    if (cmd_i.mul_prev) begin
      mul_a = prev_rd;
      mul_b = one_minus;
    end else if (cmd_i.mul_new) begin
      mul_a = q_q;
      mul_b = alpha_eff;
    end
  end

  assign prod = mul_a * mul_b;

  // Rescale with round half up
  assign rnd    = (acc_q + HALF_A) >>> FRAC_BITS;
  assign mapped = valid_q ? clamp_val(rnd, cfg_i.clamp_enable, cmin_a, cmax_a) : '0;
  assign prev_a = ACC_W'(prev_rd);
  assign delta  = rnd - prev_a;
  assign fin_a  = clamp_val(s_q, cfg_i.clamp_enable, cmin_a, cmax_a);
  assign fin    = sat_cmd(fin_a);

  always_comb begin
    c_d = c_q;
    if (cmd_i.accept) begin
      c_d = ang_ext;
    end else if (cmd_i.wrap_step && !stat_o.wrap_done) begin
      c_d = wrap_hi_q ? (c_q - TWO_PI_C) : (c_q + TWO_PI_C);
    end
  end

  always_comb begin
    acc_d = acc_q;
    if (cmd_i.gain || cmd_i.mul_prev) begin
      acc_d = ACC_W'(prod);
    end else if (cmd_i.mul_new) begin
      acc_d = acc_q + ACC_W'(prod);
    end
  end

  assign q_d = sat_cmd(mapped - ACC_W'(off_rd));

  // Slew limit against the joint's last command
  always_comb begin
    s_d = rnd;
    if (delta > step_a) begin
      s_d = prev_a + step_a;
    end else if (delta < -step_a) begin
      s_d = prev_a - step_a;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      func_q     <= func_i;
      joint_q    <= joint_i;
      valid_q    <= angle_valid_i;
      in_range_q <= stat_o.req_in_range;
      wrap_hi_q  <= (ang_ext > PI_C);
      wrap_lo_q  <= (ang_ext < -PI_C);
    end
    c_q   <= c_d;
    acc_q <= acc_d;
    if (cmd_i.mapq) begin
      q_q <= q_d;
    end
    if (cmd_i.slew) begin
      s_q <= s_d;
    end
  end

  // Commit joint state together with the load of the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_JOINTS; i++) begin
        last_q[i]   <= '0;
        latest_q[i] <= '0;
        offset_q[i] <= '0;
      end
      have_q <= 1'b0;
    end else if (cmd_i.commit) begin
      if (func_q) begin
        if (have_q) begin
          for (int i = 0; i < NUM_JOINTS; i++) begin
            offset_q[i] <= latest_q[i];
            last_q[i]   <= '0;
          end
        end
      end else if (in_range_q) begin
        last_q[idx]   <= fin;
        latest_q[idx] <= fin;
        have_q        <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      if (func_q) begin
        out_joint_q  <= '0;
        out_cmd_q    <= '0;
        out_status_q <= have_q ? ST_CAPTURED : ST_REJECTED;
      end else begin
        out_joint_q  <= joint_q;
        out_cmd_q    <= in_range_q ? fin : '0;
        out_status_q <= ST_SAMPLE;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign joint_out_o = out_joint_q;
  assign command_o   = out_cmd_q;
  assign status_o    = out_status_q;

  always_comb begin
    last_all_zero = 1'b1;
    for (int i = 0; i < NUM_JOINTS; i++) begin
      if (last_q[i] != '0) last_all_zero = 1'b0;
    end
  end

  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> out_free)
    else $error("result committed while output register busy");

  a_nonsample_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q != ST_SAMPLE)) |-> (out_cmd_q == '0))
    else $error("capture result carries a nonzero command");

  a_sample_stored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && !func_q && in_range_q) |=>
      ((last_q[idx] == out_cmd_q) && (latest_q[idx] == out_cmd_q)))
    else $error("joint state does not match delivered command");

  a_capture_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && func_q && have_q) |=> last_all_zero)
    else $error("capture left a nonzero last command");

  a_have_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(have_q))
    else $error("sample flag cleared outside reset");

endmodule

`default_nettype wire

/* rtl/joint_angle_smoothing_slew_limiter_core.sv */
`default_nettype none

// Joint angle smoother with slew-rate limit. Each input transfer is either an
// angle sample (func_i = 0) for one joint or a zero-capture command
// (func_i = 1). A sample angle (signed Q12 radians) is wrapped into plus or
// minus pi, optionally negated, scaled by the signed Q12 gain and optionally
// clamped; an invalid reading counts as zero. The joint's zero offset is
// subtracted, the value is blended with the joint's last command by
// exponential smoothing (weight smooth_alpha, Q12), the change is limited to
// step_max, the clamp is applied again and the 24-bit saturated result is
// stored and delivered. A capture copies every joint's latest command into
// its offset and clears the last commands, or reports status 2 if no sample
// has been seen since reset. A sample for a joint number of 9 or more changes
// nothing and returns command 0. Sequencing: the block handles one item at a
// time. A valid sample passes the angle wrap, which subtracts or adds one
// turn of 2*pi per cycle until the angle lies within plus or minus pi, and
// one shared 24x17 multiplier is used in three steps (gain, old-command
// weight, new-value weight) followed by slew and commit. An invalid sample
// skips the wrap and the gain step; a capture or an out-of-range joint goes
// straight to commit. The result sits in an output register, so a stalled
// result does not hold off the next input transfer; only the commit of the
// following result waits for it. Configuration writes are always ready and
// take effect the next cycle; write them only while idle.

module joint_angle_smoothing_slew_limiter_core import jss_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  // Input channel
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic                    func_i,
  input  wire logic [JOINT_W-1:0]      joint_i,
  input  wire logic                    angle_valid_i,
  input  wire logic signed [ANG_W-1:0] angle_rad_i,
  // Result channel
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic [JOINT_W-1:0]           joint_out_o,
  output logic signed [CMD_W-1:0]      command_o,
  output logic [1:0]                   status_o,
  // Configuration write channel
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data_i
);

  cfg_t     cfg;
  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // Register file for the seven settings
  jss_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Sequencer: steps the datapath through wrap, multiply, slew and commit
  jss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  // Datapath: item registers, shared multiplier, joint state, output register
  jss_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .cmd_i         (dp_cmd),
    .stat_o        (dp_stat),
    .func_i        (func_i),
    .joint_i       (joint_i),
    .angle_valid_i (angle_valid_i),
    .angle_rad_i   (angle_rad_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .joint_out_o   (joint_out_o),
    .command_o     (command_o),
    .status_o      (status_o)
  );

endmodule

`default_nettype wire

/* tb/sv/tb_joint_angle_smoothing_slew_limiter_core.sv */
`default_nettype none

module tb_joint_angle_smoothing_slew_limiter_core;
  import jss_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Angle constants in Q12: pi rounded to nearest, and 1.0
  localparam longint PiQ12 = 12868;
  localparam longint QOne  = 64'sd1 <<< FRAC_BITS;
  // Cycles without any transfer before the run is declared hung
  localparam int QuietLimit = 3000;

  typedef struct packed {
    logic [JOINT_W-1:0]      joint;
    logic signed [CMD_W-1:0] command;
    logic [1:0]              status;
  } cmd_result_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic                    func_i;
  logic [JOINT_W-1:0]      joint_i;
  logic                    angle_valid_i;
  logic signed [ANG_W-1:0] angle_rad_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic [JOINT_W-1:0]      joint_out_o;
  logic signed [CMD_W-1:0] command_o;
  logic [1:0]              status_o;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i;
  logic [CFG_DATA_W-1:0]   cfg_data_i;

  joint_angle_smoothing_slew_limiter_core dut (.*);

  // Shadow copy of the configuration registers
  longint k_gain;
  longint k_alpha;
  longint k_step;
  bit     k_clamp_en;
  longint k_clamp_min;
  longint k_clamp_max;
  bit     k_invert;

  // Shadow copy of the per-joint state
  longint cmd_hist [NUM_JOINTS];
  longint latest_cmd [NUM_JOINTS];
  longint zero_ref [NUM_JOINTS];
  bit     seen_sample;

  // Commands still owed by the block, oldest first
  cmd_result_t expected_cmds [$];
  int          mismatch_count = 0;

  // Upper bounds of the random wait each side draws per item
  int send_gap_max   = 14;
  int recv_stall_max = 14;
  int recv_hold      = 0;

  wire in_xfer  = in_valid_i && !in_stall_o;
  wire out_xfer = out_valid_o && !out_stall_i;
  wire cfg_xfer = cfg_valid_i && cfg_ready_o;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Command predictor
  // ---------------------------------------------------------------------------

  // Rescale a Q24 product back to Q12, rounding half up
  function automatic longint q_round(longint v);
    return (v + QOne / 2) >>> FRAC_BITS;
  endfunction

  function automatic longint sat_cmd(longint v);
    if (v > CMD_MAX) return CMD_MAX;
    if (v < CMD_MIN) return CMD_MIN;
    return v;
  endfunction

  // Upper bound first, so crossed bounds leave clamp_min
  function automatic longint clamp_q(longint v);
    if (!k_clamp_en) return v;
    if (v > k_clamp_max) v = k_clamp_max;
    if (v < k_clamp_min) v = k_clamp_min;
    return v;
  endfunction

  function automatic cmd_result_t predict_cmd(logic func, logic [JOINT_W-1:0] jn, logic av,
                                              logic signed [ANG_W-1:0] ang);
    cmd_result_t r;
    longint      c, m, q, prev, s, delta, alpha;
    int          i;
    r.joint   = '0;
    r.command = '0;
    r.status  = ST_SAMPLE;
    if (func) begin
      // Capture: latest commands become the new zero, history starts over
      if (!seen_sample) begin
        r.status = ST_REJECTED;
      end else begin
        for (i = 0; i < NUM_JOINTS; i++) begin
          zero_ref[i] = latest_cmd[i];
          cmd_hist[i] = 0;
        end
        r.status = ST_CAPTURED;
      end
    end else begin
      r.joint = jn;
      // Out-of-range joint: report it with a zero command, touch nothing
      if (jn < NUM_JOINTS) begin
        alpha = (k_alpha > QOne) ? QOne : k_alpha;
        q = 0;
        if (av) begin
          c = longint'(ang);
          // Wrap only outside plus or minus pi
          if (c > PiQ12 || c < -PiQ12) begin
            m = (c + PiQ12) % (2 * PiQ12);
            if (m < 0) m += 2 * PiQ12;
            c = m - PiQ12;
          end
          if (k_invert) c = -c;
          q = clamp_q(q_round(c * k_gain));
        end
        prev  = cmd_hist[jn];
        q     = sat_cmd(q - zero_ref[jn]);
        s     = q_round((QOne - alpha) * prev + alpha * q);
        delta = s - prev;
        if (delta > k_step) s = prev + k_step;
        else if (delta < -k_step) s = prev - k_step;
        s = sat_cmd(clamp_q(s));
        cmd_hist[jn]   = s;
        latest_cmd[jn] = s;
        seen_sample    = 1'b1;
        r.command      = s[CMD_W-1:0];
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: stall at random, compare each result transfer
  // ---------------------------------------------------------------------------

  // Count the drawn stall down only while a result is offered, so each
  // result waits out its full drawn stall; stall at random while idle as well.
  initial begin : result_stall_drive
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (out_valid_o && recv_hold > 0) begin
        out_stall_i <= 1'b1;
        recv_hold--;
      end else if (!out_valid_o && recv_stall_max != 0) begin
        out_stall_i <= ($urandom_range(0, 3) == 0);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    cmd_result_t want;
    if (rst_ni && out_xfer) begin
      if (expected_cmds.size() == 0) begin
        $display("%0t: unexpected result joint %0d command %0d status %0d",
                 $time, joint_out_o, command_o, status_o);
        mismatch_count++;
      end else begin
        want = expected_cmds.pop_front();
        if (joint_out_o !== want.joint) begin
          $display("%0t: joint_out expected %0d actual %0d", $time, want.joint, joint_out_o);
          mismatch_count++;
        end
        if (command_o !== want.command) begin
          $display("%0t: command expected %0d actual %0d", $time, want.command, command_o);
          mismatch_count++;
        end
        if (status_o !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
          mismatch_count++;
        end
      end
      // Draw the stall for the next result
      recv_hold = $urandom_range(0, recv_stall_max);
    end
  end

  // Hang detector: end the run once nothing has moved for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if (!rst_ni || in_xfer || out_xfer || cfg_xfer) quiet = 0;
      else quiet++;
    end
    $display("%0t: watchdog expired, %0d results outstanding", $time, expected_cmds.size());
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Idle for a random gap, offer one item, hold it until the transfer,
  // then predict its command. Valid stays high into the next item when
  // the next gap is zero.
  task automatic send_item(input logic func, input logic [JOINT_W-1:0] jn, input logic av,
                           input logic signed [ANG_W-1:0] ang);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    func_i        <= func;
    joint_i       <= jn;
    angle_valid_i <= av;
    angle_rad_i   <= ang;
    do @(posedge clk_i); while (in_stall_o);
    expected_cmds.push_back(predict_cmd(func, jn, av, ang));
  endtask

  // Drop valid, wait until every owed result is in, then let the block settle
  task automatic settle_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // One register write; mirror it into the shadow registers on transfer
  task automatic cfg_write(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] word);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= word;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_GAIN:         k_gain      = longint'($signed(word[GAIN_W-1:0]));
      CFG_SMOOTH_ALPHA: k_alpha     = longint'(word[ALPHA_W-1:0]);
      CFG_STEP_MAX:     k_step      = longint'(word[STEP_W-1:0]);
      CFG_CLAMP_ENABLE: k_clamp_en  = word[0];
      CFG_CLAMP_MIN:    k_clamp_min = longint'($signed(word[ANG_W-1:0]));
      CFG_CLAMP_MAX:    k_clamp_max = longint'($signed(word[ANG_W-1:0]));
      CFG_INVERT:       k_invert    = word[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Drain, then rewrite every register
  task automatic apply_settings(input logic [CFG_DATA_W-1:0] w_gain, w_alpha, w_step, w_en,
                                input logic [CFG_DATA_W-1:0] w_min, w_max, w_inv);
    settle_idle();
    cfg_write(CFG_GAIN, w_gain);
    cfg_write(CFG_SMOOTH_ALPHA, w_alpha);
    cfg_write(CFG_STEP_MAX, w_step);
    cfg_write(CFG_CLAMP_ENABLE, w_en);
    cfg_write(CFG_CLAMP_MIN, w_min);
    cfg_write(CFG_CLAMP_MAX, w_max);
    cfg_write(CFG_INVERT, w_inv);
  endtask

  // Mostly samples for real joints with a capture now and then; angles are
  // spread over the full range, one turn, the wrap edges and small values.
  task automatic run_random(input int count);
    logic                    func, av;
    logic [JOINT_W-1:0]      jn;
    logic signed [ANG_W-1:0] ang;
    int                      pick;
    repeat (count) begin
      func = ($urandom_range(0, 11) == 0);
      jn   = ($urandom_range(0, 9) == 0) ? JOINT_W'($urandom_range(9, 15)) :
                                           JOINT_W'($urandom_range(0, 8));
      av   = ($urandom_range(0, 7) != 0);
      case ($urandom_range(0, 3))
        0: ang = ANG_W'($urandom());
        1: begin
          pick = int'($urandom_range(0, 32'(2 * PiQ12)));
          ang  = ANG_W'(longint'(pick) - PiQ12);
        end
        2: begin
          pick = int'(PiQ12 + longint'($urandom_range(0, 3)));
          ang  = $urandom_range(0, 1) ? ANG_W'(pick) : ANG_W'(-pick);
        end
        default: begin
          pick = int'($urandom_range(0, 4000));
          ang  = ANG_W'(pick - 2000);
        end
      endcase
      send_item(func, jn, av, ang);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset configuration: early capture, angle extremes, wrap edges,
  // invalid reading, joints out of range, capture and offset use
  task automatic test_directed();
    send_item(1'b1, 4'd3, 1'b1, 18'sd1000);       // capture before any sample
    send_item(1'b0, 4'd0, 1'b1, 18'sd0);
    send_item(1'b0, 4'd1, 1'b1, 18'sd131071);
    send_item(1'b0, 4'd2, 1'b1, -18'sd131072);
    send_item(1'b0, 4'd3, 1'b1, 18'sd12868);      // exactly pi, no wrap
    send_item(1'b0, 4'd4, 1'b1, -18'sd12868);
    send_item(1'b0, 4'd5, 1'b1, 18'sd12869);      // just past pi, wraps
    send_item(1'b0, 4'd6, 1'b1, -18'sd12869);
    send_item(1'b0, 4'd7, 1'b0, 18'sd5000);       // no reading
    send_item(1'b0, 4'd8, 1'b1, 18'sd25736);
    send_item(1'b0, 4'd9, 1'b1, 18'sd1000);       // first joint out of range
    send_item(1'b0, 4'd15, 1'b1, -18'sd1);
    repeat (3) send_item(1'b0, 4'd0, 1'b1, 18'sd12868);
    send_item(1'b1, 4'd0, 1'b1, 18'sd0);          // capture offsets
    send_item(1'b0, 4'd0, 1'b1, 18'sd12868);
    send_item(1'b0, 4'd1, 1'b0, 18'sd0);
    send_item(1'b1, 4'd15, 1'b0, -18'sd77);       // capture ignores its fields
    send_item(1'b0, 4'd8, 1'b1, -18'sd131072);
  endtask

  // Corners of every register: full gain both signs, alpha at 0, 1.0 and
  // above, step 0 and full, clamp off, crossed and collapsed bounds
  task automatic test_setting_extremes();
    apply_settings(18'h07FFF, 18'd4096, 18'hFFFF, 18'd0, 18'h20000, 18'h1FFFF, 18'd0);
    run_random(50);
    apply_settings(18'h08000, 18'h1FFF, 18'd0, 18'd1, 18'h20000, 18'h1FFFF, 18'd1);
    run_random(50);
    apply_settings(18'h00000, 18'd0, 18'hFFFF, 18'd1, 18'd100, -18'sd100, 18'd0);
    run_random(50);
    apply_settings(18'h01000, 18'd1, 18'd1, 18'd1, 18'd0, 18'd0, 18'd1);
    run_random(50);
    apply_settings(18'h3FFFF, 18'd4095, 18'd300, 18'h3FFFE, 18'h1FFFF, 18'h20000, 18'h3FFFE);
    run_random(50);
  endtask

  // Random settings, with junk in the bits above each register's width
  task automatic test_random_settings();
    logic [CFG_DATA_W-1:0] w_gain, w_alpha, w_step, w_en, w_min, w_max, w_inv;
    int                    span;
    repeat (9) begin
      w_gain  = CFG_DATA_W'($urandom());
      w_alpha = CFG_DATA_W'($urandom());
      w_step  = CFG_DATA_W'($urandom());
      w_en    = CFG_DATA_W'($urandom());
      w_inv   = CFG_DATA_W'($urandom());
      w_min   = CFG_DATA_W'($urandom());
      w_max   = CFG_DATA_W'($urandom());
      if ($urandom_range(0, 3) != 0) w_alpha[ALPHA_W-1:0] = ALPHA_W'($urandom_range(0, 4096));
      if ($urandom_range(0, 3) != 0) w_step[STEP_W-1:0] = STEP_W'($urandom_range(0, 1500));
      if ($urandom_range(0, 3) != 0) begin
        span  = int'($urandom_range(0, 20000));
        w_min = CFG_DATA_W'(-span);
        w_max = CFG_DATA_W'($urandom_range(0, 20000));
      end
      apply_settings(w_gain, w_alpha, w_step, w_en, w_min, w_max, w_inv);
      run_random(80);
    end
  endtask

  // Full rate on both sides
  task automatic test_back_to_back();
    send_gap_max   = 0;
    recv_stall_max = 0;
    run_random(200);
    send_gap_max   = 14;
    recv_stall_max = 14;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    in_valid_i    = 1'b0;
    func_i        = 1'b0;
    joint_i       = '0;
    angle_valid_i = 1'b0;
    angle_rad_i   = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_GAIN;
    cfg_data_i    = '0;
    rst_ni        = 1'b0;

    // Reset values of the shadow registers and state
    k_gain      = 2048;
    k_alpha     = 2048;
    k_step      = 205;
    k_clamp_en  = 1'b1;
    k_clamp_min = -6431;
    k_clamp_max = 6431;
    k_invert    = 1'b0;
    foreach (cmd_hist[i]) begin
      cmd_hist[i]   = 0;
      latest_cmd[i] = 0;
      zero_ref[i]   = 0;
    end
    seen_sample = 1'b0;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_setting_extremes();
    test_random_settings();
    test_back_to_back();
    settle_idle();

    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
